@@ rtl/core/tpq_pkg.sv @@
// package: types, sizes and codes shared by the two-class priority queue
package tpq_pkg;

    localparam int PREF_DEPTH   = 16;
    localparam int NORMAL_DEPTH = 16;

    localparam int CODE_W = 40;

    // index, count and sum widths per class
    localparam int PREF_AW = (PREF_DEPTH > 1) ? $clog2(PREF_DEPTH) : 1;
    localparam int PREF_CW = $clog2(PREF_DEPTH + 1);
    localparam int PREF_SW = PREF_CW + 1;
    localparam int NORM_AW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int NORM_CW = $clog2(NORMAL_DEPTH + 1);
    localparam int NORM_SW = NORM_CW + 1;

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = 1;
    localparam int CQ_CW    = 2;

    // request codes
    localparam logic [1:0] REQ_NORMAL = 2'd0;
    localparam logic [1:0] REQ_PREF   = 2'd1;
    localparam logic [1:0] REQ_SERVE  = 2'd2;
    localparam logic [1:0] REQ_LIST   = 2'd3;

    // status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_SERVED   = 3'd1;
    localparam logic [2:0] ST_LISTED   = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // command kinds after classification
    localparam logic [1:0] CMD_ARRIVE = 2'd0;
    localparam logic [1:0] CMD_SERVE  = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CODE_W-1:0] code;
    } t_in_beat;

    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic              is_preferential;
        logic [2:0]        status;
        logic              last;
    } t_out_beat;

    typedef struct packed {
        logic [1:0]        kind;
        logic              pref;
        logic [CODE_W-1:0] code;
    } t_cmd;

endpackage

@@ rtl/core/two_class_priority_queue.sv @@
// top level: two-class strict priority queue of 40-bit codes
// A request beat carries a type and a code. Normal arrivals join the tail of the
// normal class, preferential arrivals the tail of the preferential class; every
// preferential entry is served ahead of any normal one. Each request gives one
// result beat, except a list, which gives one beat per queued entry in service
// order with last set on the final one. A two-entry command queue takes
// request beats while earlier ones are carried out. An arrival, a full reject or an
// empty report goes from the command straight into the result register. A serve
// takes the command, reads the store and delivers; a list takes the command, reads
// the first entry, then delivers each entry while reading the next. Each class store
// has a registered read port, and the back handles one command at a time. A stall
// on the result side holds the result register and, once the command queue fills,
// stalls the request side. No clearing pass is needed after reset: head and count
// registers alone mark what each store holds.
module two_class_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tpq_pkg::t_in_beat  i_in_beat,
    // result side
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tpq_pkg::t_out_beat o_out_beat
);

    // classified command from front to back
    logic          cmd_valid;
    tpq_pkg::t_cmd cmd;
    logic          cmd_pop;

    // front: accept and classify, queue up commands
    tpq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: stores, counts, serve and list sequencing, result register
    tpq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

@@ rtl/core/tpq_front.sv @@
// front: accepts request beats, classifies them and queues commands for the back
module tpq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tpq_pkg::t_in_beat i_in_beat,
    output logic            o_cmd_valid,
    output tpq_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_pop
);

    tpq_pkg::t_cmd                r_q [tpq_pkg::CQ_DEPTH];
    logic [tpq_pkg::CQ_AW-1:0]    r_wp, n_wp;
    logic [tpq_pkg::CQ_AW-1:0]    r_rp, n_rp;
    logic [tpq_pkg::CQ_CW-1:0]    r_cnt, n_cnt;
    logic                         push;
    logic                         pop;
    tpq_pkg::t_cmd                cls;

    // classify the request
    always_comb begin
        cls.code = i_in_beat.code;
        cls.pref = 1'b0;
        unique case (i_in_beat.req_type)
            tpq_pkg::REQ_NORMAL: cls.kind = tpq_pkg::CMD_ARRIVE;
            tpq_pkg::REQ_PREF: begin
                cls.kind = tpq_pkg::CMD_ARRIVE;
                cls.pref = 1'b1;
            end
            tpq_pkg::REQ_SERVE:  cls.kind = tpq_pkg::CMD_SERVE;
            default:             cls.kind = tpq_pkg::CMD_LIST;
        endcase
    end

    assign o_in_stall  = (r_cnt == tpq_pkg::CQ_CW'(tpq_pkg::CQ_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + tpq_pkg::CQ_CW'(push) - tpq_pkg::CQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

@@ rtl/core/tpq_back.sv @@
// back: class stores, head and count registers, serve and list sequencer, output register
module tpq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  tpq_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tpq_pkg::t_out_beat o_out_beat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    localparam int PAW = tpq_pkg::PREF_AW;
    localparam int PCW = tpq_pkg::PREF_CW;
    localparam int PSW = tpq_pkg::PREF_SW;
    localparam int NAW = tpq_pkg::NORM_AW;
    localparam int NCW = tpq_pkg::NORM_CW;
    localparam int NSW = tpq_pkg::NORM_SW;
    localparam int CW  = tpq_pkg::CODE_W;

    logic [CW-1:0] pref_mem [tpq_pkg::PREF_DEPTH];
    logic [CW-1:0] norm_mem [tpq_pkg::NORMAL_DEPTH];

    logic [1:0]   r_state, n_state;
    logic [PAW-1:0] r_pref_head, n_pref_head;
    logic [PCW-1:0] r_pref_cnt, n_pref_cnt;
    logic [NAW-1:0] r_norm_head, n_norm_head;
    logic [NCW-1:0] r_norm_cnt, n_norm_cnt;
    logic [PAW-1:0] r_pref_ptr, n_pref_ptr;
    logic [PCW-1:0] r_pref_rem, n_pref_rem;
    logic [NAW-1:0] r_norm_ptr, n_norm_ptr;
    logic [NCW-1:0] r_norm_rem, n_norm_rem;
    logic         r_rd_pref, n_rd_pref;
    logic         r_rd_last, n_rd_last;
    logic [2:0]   r_rd_status, n_rd_status;
    logic [CW-1:0] r_pref_rdata;
    logic [CW-1:0] r_norm_rdata;
    logic         r_out_valid, n_out_valid;
    tpq_pkg::t_out_beat r_out, n_out;

    logic           out_free;
    logic           issue_go;
    logic           sel_pref;
    logic           iss_last;
    logic           pref_we;
    logic           norm_we;
    logic [PSW-1:0] pref_tsum;
    logic [PAW-1:0] pref_tail;
    logic [NSW-1:0] norm_tsum;
    logic [NAW-1:0] norm_tail;
    logic [PAW-1:0] pref_head_inc;
    logic [NAW-1:0] norm_head_inc;
    logic [PAW-1:0] pref_ptr_inc;
    logic [NAW-1:0] norm_ptr_inc;
    logic           pref_full;
    logic           norm_full;

    // tail positions and wrapped increments
    always_comb begin
        pref_tsum = PSW'(r_pref_head) + PSW'(r_pref_cnt);
        pref_tail = (pref_tsum >= PSW'(tpq_pkg::PREF_DEPTH))
                  ? PAW'(pref_tsum - PSW'(tpq_pkg::PREF_DEPTH)) : PAW'(pref_tsum);
        norm_tsum = NSW'(r_norm_head) + NSW'(r_norm_cnt);
        norm_tail = (norm_tsum >= NSW'(tpq_pkg::NORMAL_DEPTH))
                  ? NAW'(norm_tsum - NSW'(tpq_pkg::NORMAL_DEPTH)) : NAW'(norm_tsum);
        pref_head_inc = (r_pref_head == PAW'(tpq_pkg::PREF_DEPTH - 1))
                      ? '0 : r_pref_head + 1'b1;
        norm_head_inc = (r_norm_head == NAW'(tpq_pkg::NORMAL_DEPTH - 1))
                      ? '0 : r_norm_head + 1'b1;
        pref_ptr_inc  = (r_pref_ptr == PAW'(tpq_pkg::PREF_DEPTH - 1))
                      ? '0 : r_pref_ptr + 1'b1;
        norm_ptr_inc  = (r_norm_ptr == NAW'(tpq_pkg::NORMAL_DEPTH - 1))
                      ? '0 : r_norm_ptr + 1'b1;
        pref_full = (r_pref_cnt == PCW'(tpq_pkg::PREF_DEPTH));
        norm_full = (r_norm_cnt == NCW'(tpq_pkg::NORMAL_DEPTH));
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign sel_pref = (r_pref_rem != '0);
    assign iss_last = sel_pref ? ((r_pref_rem == PCW'(1)) && (r_norm_rem == '0))
                               : (r_norm_rem == NCW'(1));

    always_comb begin
        n_state     = r_state;
        n_pref_head = r_pref_head;
        n_pref_cnt  = r_pref_cnt;
        n_norm_head = r_norm_head;
        n_norm_cnt  = r_norm_cnt;
        n_pref_ptr  = r_pref_ptr;
        n_pref_rem  = r_pref_rem;
        n_norm_ptr  = r_norm_ptr;
        n_norm_rem  = r_norm_rem;
        n_rd_pref   = r_rd_pref;
        n_rd_last   = r_rd_last;
        n_rd_status = r_rd_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        issue_go    = 1'b0;
        pref_we     = 1'b0;
        norm_we     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        tpq_pkg::CMD_ARRIVE: begin
                            n_out_valid           = 1'b1;
                            n_out.code_out        = '0;
                            n_out.is_preferential = i_cmd.pref;
                            n_out.last            = 1'b1;
                            if (i_cmd.pref) begin
                                n_out.status = pref_full ? tpq_pkg::ST_FULL
                                                         : tpq_pkg::ST_ACCEPTED;
                                if (!pref_full) begin
                                    pref_we    = 1'b1;
                                    n_pref_cnt = r_pref_cnt + 1'b1;
                                end
                            end else begin
                                n_out.status = norm_full ? tpq_pkg::ST_FULL
                                                         : tpq_pkg::ST_ACCEPTED;
                                if (!norm_full) begin
                                    norm_we    = 1'b1;
                                    n_norm_cnt = r_norm_cnt + 1'b1;
                                end
                            end
                        end
                        tpq_pkg::CMD_SERVE: begin
                            n_rd_status = tpq_pkg::ST_SERVED;
                            n_pref_ptr  = r_pref_head;
                            n_norm_ptr  = r_norm_head;
                            n_pref_rem  = '0;
                            n_norm_rem  = '0;
                            if (r_pref_cnt != '0) begin
                                n_pref_rem  = PCW'(1);
                                n_pref_head = pref_head_inc;
                                n_pref_cnt  = r_pref_cnt - 1'b1;
                                n_state     = S_ISSUE;
                            end else if (r_norm_cnt != '0) begin
                                n_norm_rem  = NCW'(1);
                                n_norm_head = norm_head_inc;
                                n_norm_cnt  = r_norm_cnt - 1'b1;
                                n_state     = S_ISSUE;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out       = '{code_out: '0, is_preferential: 1'b0,
                                                status: tpq_pkg::ST_EMPTY, last: 1'b1};
                            end
                        end
                        tpq_pkg::CMD_LIST: begin
                            n_rd_status = tpq_pkg::ST_LISTED;
                            n_pref_ptr  = r_pref_head;
                            n_norm_ptr  = r_norm_head;
                            n_pref_rem  = r_pref_cnt;
                            n_norm_rem  = r_norm_cnt;
                            if ((r_pref_cnt == '0) && (r_norm_cnt == '0)) begin
                                n_out_valid = 1'b1;
                                n_out       = '{code_out: '0, is_preferential: 1'b0,
                                                status: tpq_pkg::ST_EMPTY, last: 1'b1};
                            end else begin
                                n_state = S_ISSUE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ISSUE: begin
                issue_go = 1'b1;
                n_state  = S_READ;
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.code_out        = r_rd_pref ? r_pref_rdata : r_norm_rdata;
                    n_out.is_preferential = r_rd_pref;
                    n_out.status          = r_rd_status;
                    n_out.last            = r_rd_last;
                    if (r_rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        issue_go = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        // read of the next entry in service order
        if (issue_go) begin
            n_rd_pref = sel_pref;
            n_rd_last = iss_last;
            if (sel_pref) begin
                n_pref_ptr = pref_ptr_inc;
                n_pref_rem = r_pref_rem - 1'b1;
            end else begin
                n_norm_ptr = norm_ptr_inc;
                n_norm_rem = r_norm_rem - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pref_head <= '0;
            r_pref_cnt  <= '0;
            r_norm_head <= '0;
            r_norm_cnt  <= '0;
            r_pref_rem  <= '0;
            r_norm_rem  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pref_head <= n_pref_head;
            r_pref_cnt  <= n_pref_cnt;
            r_norm_head <= n_norm_head;
            r_norm_cnt  <= n_norm_cnt;
            r_pref_rem  <= n_pref_rem;
            r_norm_rem  <= n_norm_rem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pref_ptr  <= n_pref_ptr;
        r_norm_ptr  <= n_norm_ptr;
        r_rd_pref   <= n_rd_pref;
        r_rd_last   <= n_rd_last;
        r_rd_status <= n_rd_status;
        r_out       <= n_out;
    end

    // class stores, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (pref_we) begin
            pref_mem[pref_tail] <= i_cmd.code;
        end
        if (issue_go && sel_pref) begin
            r_pref_rdata <= pref_mem[r_pref_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (norm_we) begin
            norm_mem[norm_tail] <= i_cmd.code;
        end
        if (issue_go && !sel_pref) begin
            r_norm_rdata <= norm_mem[r_norm_ptr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

@@ rtl/core/tpq_checker.sv @@
// checker: port-level assertions for the priority queue, bound to the top level
module tpq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tpq_pkg::t_out_beat o_out_beat
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled result beat changed");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    // only list entries may leave last low
    a_last_only_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status != tpq_pkg::ST_LISTED) |-> o_out_beat.last)
        else $error("single-beat result without last");

    // arrival and empty reports carry no code
    a_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_beat.status == tpq_pkg::ST_ACCEPTED)
            || (o_out_beat.status == tpq_pkg::ST_FULL)
            || (o_out_beat.status == tpq_pkg::ST_EMPTY))
        |-> (o_out_beat.code_out == '0))
        else $error("code on a result that carries none");

    // an empty report is never marked preferential
    a_empty_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status == tpq_pkg::ST_EMPTY)
        |-> !o_out_beat.is_preferential)
        else $error("empty report marked preferential");

endmodule

bind two_class_priority_queue tpq_checker u_tpq_checker (.*);

@@ tb/sv/two_class_priority_queue_tb.sv @@
// testbench: scripted and random request beats for the two-class priority queue, self-checked
module two_class_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpq_pkg::*;

    localparam int SCRIPT_ROWS = 15;
    localparam int PHASES      = 4;
    localparam int PHASE_BEATS = 28;
    localparam int TAIL_CYCLES = 40;

    // one row of the scripted part; want_* only matter on pinned rows
    typedef struct packed {
        logic [1:0]        req;
        logic [CODE_W-1:0] code;
        logic [5:0]        reps;
        logic              pinned;
        logic [CODE_W-1:0] want_code;
        logic              want_pref;
        logic [2:0]        want_status;
    } t_script_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_beat   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_beat;

    two_class_priority_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of both classes, kept in step with accepted request beats
    logic [CODE_W-1:0] vip_slot [PREF_DEPTH];
    logic [CODE_W-1:0] std_slot [NORMAL_DEPTH];
    int                vip_head = 0;
    int                vip_fill = 0;
    int                std_head = 0;
    int                std_fill = 0;

    // result beats still owed by the queue, oldest first
    t_out_beat replies_due [$];

    // run bookkeeping
    bit quiet        = 1'b0;  // no idling on either side when set
    int hold_left    = 0;
    int mismatches   = 0;
    int beats_seen   = 0;
    int list_run     = 0;
    int list_longest = 0;
    int full_seen    = 0;
    int empty_seen   = 0;
    int req_count [4];

    t_script_row script [SCRIPT_ROWS];

    function automatic t_script_row script_row(input logic [1:0] req,
                                               input logic [CODE_W-1:0] code,
                                               input int reps, input logic pinned,
                                               input logic [CODE_W-1:0] want_code,
                                               input logic want_pref,
                                               input logic [2:0] want_status);
        script_row = {req, code, 6'(reps), pinned, want_code, want_pref, want_status};
    endfunction

    function automatic void owe(input logic [CODE_W-1:0] cd, input logic pref,
                                input logic [2:0] st, input logic last);
        t_out_beat b;
        b.code_out        = cd;
        b.is_preferential = pref;
        b.status          = st;
        b.last            = last;
        replies_due.push_back(b);
    endfunction

    // apply one accepted request to the shadow queue and queue up what it owes;
    // a pinned row replaces the computed beat by the one typed into the script
    function automatic void queue_step(input logic [1:0] req, input logic [CODE_W-1:0] cd,
                                       input logic pinned, input t_out_beat want);
        int base;
        int total;
        int k;
        base = replies_due.size();
        case (req)
            REQ_NORMAL: begin
                if (std_fill >= NORMAL_DEPTH) begin
                    owe('0, 1'b0, ST_FULL, 1'b1);
                end else begin
                    std_slot[(std_head + std_fill) % NORMAL_DEPTH] = cd;
                    std_fill++;
                    owe('0, 1'b0, ST_ACCEPTED, 1'b1);
                end
            end
            REQ_PREF: begin
                if (vip_fill >= PREF_DEPTH) begin
                    owe('0, 1'b1, ST_FULL, 1'b1);
                end else begin
                    vip_slot[(vip_head + vip_fill) % PREF_DEPTH] = cd;
                    vip_fill++;
                    owe('0, 1'b1, ST_ACCEPTED, 1'b1);
                end
            end
            REQ_SERVE: begin
                // preferential class always drains first
                if (vip_fill > 0) begin
                    owe(vip_slot[vip_head], 1'b1, ST_SERVED, 1'b1);
                    vip_head = (vip_head + 1) % PREF_DEPTH;
                    vip_fill--;
                end else if (std_fill > 0) begin
                    owe(std_slot[std_head], 1'b0, ST_SERVED, 1'b1);
                    std_head = (std_head + 1) % NORMAL_DEPTH;
                    std_fill--;
                end else begin
                    owe('0, 1'b0, ST_EMPTY, 1'b1);
                end
            end
            default: begin
                total = vip_fill + std_fill;
                if (total == 0) begin
                    owe('0, 1'b0, ST_EMPTY, 1'b1);
                end else begin
                    // service order: preferential entries, then normal ones
                    for (k = 0; k < vip_fill; k++)
                        owe(vip_slot[(vip_head + k) % PREF_DEPTH], 1'b1, ST_LISTED,
                            k + 1 == total);
                    for (k = 0; k < std_fill; k++)
                        owe(std_slot[(std_head + k) % NORMAL_DEPTH], 1'b0, ST_LISTED,
                            vip_fill + k + 1 == total);
                end
            end
        endcase
        if (pinned) begin
            while (replies_due.size() > base)
                void'(replies_due.pop_back());
            replies_due.push_back(want);
        end
    endfunction

    task automatic flag_mismatch(input t_out_beat want, input t_out_beat got,
                                 input bit stray);
        mismatches++;
        if (mismatches <= 10) begin
            if (stray) begin
                $display("[%0t] stray result beat: code=%h pref=%0d st=%0d last=%0d",
                         $realtime, got.code_out, got.is_preferential, got.status, got.last);
            end else begin
                $write("[%0t] result mismatch: want code=%h pref=%0d st=%0d last=%0d,",
                       $realtime, want.code_out, want.is_preferential, want.status,
                       want.last);
                $display(" got code=%h pref=%0d st=%0d last=%0d",
                         got.code_out, got.is_preferential, got.status, got.last);
            end
        end
    endtask

    // result side: compare each accepted beat with the oldest owed one
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_seen++;
            if (o_out_beat.status == ST_FULL)
                full_seen++;
            if (o_out_beat.status == ST_EMPTY)
                empty_seen++;
            if (o_out_beat.status == ST_LISTED) begin
                list_run++;
                if (list_run > list_longest)
                    list_longest = list_run;
            end
            if (o_out_beat.last)
                list_run = 0;
            if (replies_due.size() == 0) begin
                flag_mismatch('0, o_out_beat, 1'b1);
            end else begin
                want = replies_due.pop_front();
                if (o_out_beat.code_out !== want.code_out
                        || o_out_beat.is_preferential !== want.is_preferential
                        || o_out_beat.status !== want.status
                        || o_out_beat.last !== want.last)
                    flag_mismatch(want, o_out_beat, 1'b0);
            end
        end
    end

    // receiver stalls in bursts of random length, none once quiet
    always @(negedge i_clk) begin
        if (quiet)
            hold_left = 0;
        else if (hold_left > 0)
            hold_left--;
        else if ($urandom_range(0, 5) == 0)
            hold_left = $urandom_range(1, 13);
        i_out_stall <= (hold_left > 0);
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_req(input logic [1:0] req, input logic [CODE_W-1:0] cd,
                            input logic pinned, input t_out_beat want);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_in_beat.req_type <= req;
        i_in_beat.code     <= cd;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        req_count[req]++;
        queue_step(req, cd, pinned, want);
        @(negedge i_clk);
    endtask

    initial begin
        int r;
        int k;
        int phase;
        int pick;
        int w_serve;
        int w_list;
        int w_pref;
        logic [1:0]        req;
        logic [CODE_W-1:0] cd;
        t_out_beat         want;

        for (k = 0; k < 4; k++)
            req_count[k] = 0;

        // scripted part: empty reports, code extremes, ignored code on serve and
        // list, both classes filled to the brim and rejected, a full-depth list,
        // then the preferential tail wrapping around its store
        script[0]  = script_row(REQ_SERVE, 40'hFF_FFFF_FFFF, 1, 1'b1, '0, 1'b0, ST_EMPTY);
        script[1]  = script_row(REQ_LIST, 40'h5A_5A5A_5A5A, 1, 1'b1, '0, 1'b0, ST_EMPTY);
        script[2]  = script_row(REQ_NORMAL, 40'h0, 1, 1'b1, '0, 1'b0, ST_ACCEPTED);
        script[3]  = script_row(REQ_NORMAL, 40'hFF_FFFF_FFFF, 1, 1'b1, '0, 1'b0, ST_ACCEPTED);
        script[4]  = script_row(REQ_PREF, "p0001", 1, 1'b1, '0, 1'b1, ST_ACCEPTED);
        script[5]  = script_row(REQ_PREF, 40'hFF_FFFF_FFFF, 1, 1'b1, '0, 1'b1, ST_ACCEPTED);
        script[6]  = script_row(REQ_LIST, 40'h0, 1, 1'b0, '0, 1'b0, ST_LISTED);
        script[7]  = script_row(REQ_SERVE, 40'hA5_A5A5_A5A5, 3, 1'b0, '0, 1'b0, ST_SERVED);
        script[8]  = script_row(REQ_PREF, "p1000", 16, 1'b0, '0, 1'b1, ST_ACCEPTED);
        script[9]  = script_row(REQ_PREF, "p9999", 1, 1'b1, '0, 1'b1, ST_FULL);
        script[10] = script_row(REQ_NORMAL, "n2000", 15, 1'b0, '0, 1'b0, ST_ACCEPTED);
        script[11] = script_row(REQ_NORMAL, "n9999", 1, 1'b1, '0, 1'b0, ST_FULL);
        script[12] = script_row(REQ_LIST, 40'h0, 1, 1'b0, '0, 1'b0, ST_LISTED);
        script[13] = script_row(REQ_SERVE, 40'h0, 2, 1'b0, '0, 1'b0, ST_SERVED);
        script[14] = script_row(REQ_PREF, "p4000", 2, 1'b0, '0, 1'b1, ST_ACCEPTED);

        // synchronous reset held low from time zero, released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < SCRIPT_ROWS; r++) begin
            want.code_out        = script[r].want_code;
            want.is_preferential = script[r].want_pref;
            want.status          = script[r].want_status;
            want.last            = 1'b1;
            for (k = 0; k < script[r].reps; k++)
                send_req(script[r].req, script[r].code + 40'(k), script[r].pinned, want);
        end

        // random part: a draining phase first (both classes start full), then a
        // filling phase, then two mixed ones; the last one runs without idling
        for (phase = 0; phase < PHASES; phase++) begin
            // hold the request side until every owed beat has arrived
            i_in_valid <= 1'b0;
            while (replies_due.size() != 0)
                @(negedge i_clk);
            @(negedge i_clk);
            if (phase == PHASES - 1)
                quiet = 1'b1;
            case (phase)
                0: begin w_serve = 55; w_list = 10; w_pref = 15; end
                1: begin w_serve = 15; w_list = 10; w_pref = 35; end
                default: begin w_serve = 35; w_list = 10; w_pref = 25; end
            endcase
            for (k = 0; k < PHASE_BEATS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < w_serve)
                    req = REQ_SERVE;
                else if (pick < w_serve + w_list)
                    req = REQ_LIST;
                else if (pick < w_serve + w_list + w_pref)
                    req = REQ_PREF;
                else
                    req = REQ_NORMAL;
                // mostly printable five-character codes, the rest raw bits
                if ($urandom_range(0, 2) != 0)
                    cd = {8'($urandom_range(32, 126)), 8'($urandom_range(32, 126)),
                          8'($urandom_range(32, 126)), 8'($urandom_range(32, 126)),
                          8'($urandom_range(32, 126))};
                else
                    cd = {8'($urandom), 32'($urandom)};
                send_req(req, cd, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        // drain what is still owed, then watch for strays
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("requests: %0d normal, %0d pref, %0d serve, %0d list; %0d beats checked",
                 req_count[REQ_NORMAL], req_count[REQ_PREF], req_count[REQ_SERVE],
                 req_count[REQ_LIST], beats_seen);
        $display("longest list %0d beats, %0d full rejects, %0d empty reports, %0d mismatches",
                 list_longest, full_seen, empty_seen, mismatches);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("two_class_priority_queue verification clean");
        end else begin
            $display("two_class_priority_queue verification failed");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #4_000_000;
        $display("two_class_priority_queue verification failed");
        $finish;
    end

endmodule
